FILE: rtl/hfwt_pkg.sv
// ----------------------------------------------------------------------------
// hfwt_pkg
// shared types and constants of the header field word tokenizer
// ----------------------------------------------------------------------------
package hfwt_pkg;

	// character codes
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// default depth of the queue between front and back
	localparam int QueueDepthDefault = 4;

	typedef enum logic [2:0] {
		TK_CHAR   = 3'd0,
		TK_WORD   = 3'd1,
		TK_PHRASE = 3'd2,
		TK_RTRIM  = 3'd3,
		TK_LABEL  = 3'd4
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] chr;
	} tok_t;

	// one queue entry holds every token of one input transfer
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} entry_t;

endpackage

FILE: rtl/hfwt_front.sv
// ----------------------------------------------------------------------------
// hfwt_front
// accepts input bytes, tracks tokenizer mode and flags, builds queue entries
// ----------------------------------------------------------------------------
module hfwt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              end_mark,
	input  logic              q_full,
	output logic              push_valid,
	output hfwt_pkg::entry_t  push_data
);

	typedef struct packed {
		logic in_word;
		logic esc;
		logic label;
		logic nl_seen;
	} flags_t;

	typedef struct packed {
		flags_t      st;
		logic [1:0]  n;
		hfwt_pkg::tok_t t0;
		hfwt_pkg::tok_t t1;
	} step_t;

	function automatic hfwt_pkg::tok_t mk(hfwt_pkg::tok_kind_t k, logic [7:0] c);
		hfwt_pkg::tok_t t;
		t.kind = k;
		t.chr  = (k == hfwt_pkg::TK_CHAR) ? c : 8'h00;
		return t;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == hfwt_pkg::CH_SP || c == hfwt_pkg::CH_TAB || c == hfwt_pkg::CH_VT
			|| c == hfwt_pkg::CH_FF || c == hfwt_pkg::CH_CR;
	endfunction

	function automatic step_t word_step(flags_t s, logic [7:0] ch);
		step_t r;
		r.st = s;
		r.n  = 2'd0;
		r.t0 = mk(hfwt_pkg::TK_CHAR, 8'h00);
		r.t1 = mk(hfwt_pkg::TK_CHAR, 8'h00);
		if (s.nl_seen) begin
			r.st.nl_seen = 1'b0;
			if (ch == hfwt_pkg::CH_NL) begin
				r.n = 2'd2;
				r.t0 = mk(hfwt_pkg::TK_WORD, 8'h00);
				r.t1 = mk(hfwt_pkg::TK_PHRASE, 8'h00);
				r.st.in_word = 1'b0;
				r.st.esc = 1'b0;
				r.st.label = 1'b1;
			end else if (is_space(ch)) begin
				// folded continuation joins with one space
				r.n = 2'd1;
				r.t0 = mk(hfwt_pkg::TK_CHAR, hfwt_pkg::CH_SP);
				r.st.in_word = 1'b0;
			end else if (ch == hfwt_pkg::CH_BSL) begin
				r.n = 2'd1;
				r.t0 = mk(hfwt_pkg::TK_WORD, 8'h00);
				r.st.esc = 1'b1;
				r.st.label = 1'b1;
			end else begin
				r.n = 2'd2;
				r.t0 = mk(hfwt_pkg::TK_WORD, 8'h00);
				r.t1 = mk(hfwt_pkg::TK_CHAR, ch);
				r.st.label = 1'b1;
			end
		end else if (s.esc) begin
			r.st.esc = 1'b0;
			r.n = 2'd1;
			r.t0 = mk(hfwt_pkg::TK_CHAR, ch);
		end else if (ch == hfwt_pkg::CH_NL) begin
			r.n = 2'd1;
			r.t0 = mk(hfwt_pkg::TK_RTRIM, 8'h00);
			r.st.nl_seen = 1'b1;
		end else if (ch == hfwt_pkg::CH_BSL) begin
			r.st.esc = 1'b1;
		end else if (s.label && ch == hfwt_pkg::CH_COLON) begin
			r.n = 2'd2;
			r.t0 = mk(hfwt_pkg::TK_RTRIM, 8'h00);
			r.t1 = mk(hfwt_pkg::TK_LABEL, 8'h00);
			r.st.in_word = 1'b0;
			r.st.label = 1'b0;
		end else begin
			r.n = 2'd1;
			r.t0 = mk(hfwt_pkg::TK_CHAR, ch);
		end
		return r;
	endfunction

	function automatic step_t skip_step(flags_t s, logic [7:0] ch);
		step_t  r;
		flags_t s2;
		r.st = s;
		r.n  = 2'd0;
		r.t0 = mk(hfwt_pkg::TK_CHAR, 8'h00);
		r.t1 = mk(hfwt_pkg::TK_CHAR, 8'h00);
		s2 = s;
		if (s.esc) begin
			r.st.esc = 1'b0;
			r.st.in_word = 1'b1;
			r.n = 2'd1;
			r.t0 = mk(hfwt_pkg::TK_CHAR, ch);
		end else if (ch == hfwt_pkg::CH_NL) begin
			if (!s.label) begin
				s2.in_word = 1'b1;
				r = word_step(s2, ch);
			end
		end else if (is_space(ch)) begin
			r.n = 2'd0;
		end else if (ch == hfwt_pkg::CH_BSL) begin
			r.st.esc = 1'b1;
		end else begin
			r.st.in_word = 1'b1;
			r.n = 2'd1;
			r.t0 = mk(hfwt_pkg::TK_CHAR, ch);
		end
		return r;
	endfunction

	flags_t     flags_q;
	step_t      nxt;
	logic [7:0] ch;
	logic       drop;
	logic       accept;

	assign ch     = end_mark ? hfwt_pkg::CH_NL : data_byte;
	assign drop   = !end_mark && data_byte == hfwt_pkg::CH_CR;
	assign nxt    = flags_q.in_word ? word_step(flags_q, ch) : skip_step(flags_q, ch);
	assign in_stall = q_full;
	assign accept = in_valid && !in_stall;

	assign push_valid     = accept && !drop && nxt.n != 2'd0;
	assign push_data.two  = nxt.n == 2'd2;
	assign push_data.t0   = nxt.t0;
	assign push_data.t1   = nxt.t1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '{in_word: 1'b0, esc: 1'b0, label: 1'b1, nl_seen: 1'b0};
		end else if (accept && !drop) begin
			flags_q <= nxt.st;
		end
	end

endmodule

FILE: rtl/hfwt_queue.sv
// ----------------------------------------------------------------------------
// hfwt_queue
// small entry queue that decouples the front from the back
// ----------------------------------------------------------------------------
module hfwt_queue #(
	parameter int Depth = hfwt_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  hfwt_pkg::entry_t  push_data,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop,
	output hfwt_pkg::entry_t  pop_data
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	hfwt_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CntFull;
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// occupancy never exceeds the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("queue count beyond depth");

	// the front never offers an entry while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push_valid)
		else $error("push while queue full");

	// a lone push raises occupancy by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");

endmodule

FILE: rtl/hfwt_back.sv
// ----------------------------------------------------------------------------
// hfwt_back
// serialises queue entries into single tokens behind an output register
// ----------------------------------------------------------------------------
module hfwt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  hfwt_pkg::entry_t  pop_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        token_kind,
	output logic [7:0]        token_char,
	output logic              last_of_run
);

	logic           valid_q;
	logic           second_q;
	hfwt_pkg::tok_t tok_q;
	logic           last_q;
	logic           load;

	assign load = !valid_q || !out_stall;
	// pop once the final token of the head entry goes into the register
	assign pop  = load && pop_valid && (!pop_data.two || second_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			valid_q <= pop_valid;
			if (pop_valid) begin
				second_q <= pop_data.two && !second_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			tok_q  <= (pop_data.two && second_q) ? pop_data.t1 : pop_data.t0;
			last_q <= !pop_data.two || second_q;
		end
	end

	assign out_valid   = valid_q;
	assign token_kind  = tok_q.kind;
	assign token_char  = tok_q.chr;
	assign last_of_run = last_q;

endmodule

FILE: rtl/header_field_word_tokenizer_top.sv
// ----------------------------------------------------------------------------
// header_field_word_tokenizer_top
// header text tokenizer with a decoupled classify front and token back end
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one byte (data_byte) or an end
// mark (end_mark, acts as a newline) per transfer
// output channel: out_valid / out_stall carry one token per transfer:
// token_kind, token_char (zero unless a literal) and last_of_run on the
// final token caused by one input transfer
// the front decides all tokens of an input in the cycle it is accepted and
// writes them as one entry into a small queue; carriage returns and
// swallowed bytes write nothing
// path: a token passes the queue memory and then the output register before
// it appears on the output, even when the queue is empty
// throughput: one input transfer per cycle while the queue is not full; the
// back end drains one token per cycle while out_stall is low, so two tokens
// of one input occupy it longer, which the queue (QueueDepth entries) absorbs
// in_stall rises only when the queue is full; out_stall holds the output
// register, the queue then fills and finally stalls the input
// reset: flags return to skipping whitespace with a field name expected,
// the queue empties and out_valid drops
// ----------------------------------------------------------------------------
module header_field_word_tokenizer_top #(
	parameter int QueueDepth = hfwt_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_mark,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] token_kind,
	output logic [7:0] token_char,
	output logic       last_of_run
);

	// entry path between the parts
	logic             push_valid;
	hfwt_pkg::entry_t push_data;
	logic             q_full;
	logic             pop_valid;
	logic             pop;
	hfwt_pkg::entry_t pop_data;

	// front: classification, flag state, entry building
	hfwt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.end_mark   (end_mark),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// queue: lets the front run while the back end is stalled or busy
	hfwt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (q_full),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// back: one token per output transfer from a registered stage
	hfwt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.token_char  (token_char),
		.last_of_run (last_of_run)
	);

endmodule
